// File: rtl/core/hermite_interpolation_macros.svh
// Assertion macros shared by the hermite interpolation RTL.
`ifndef HERMITE_INTERPOLATION_MACROS_SVH
`define HERMITE_INTERPOLATION_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset.
`define HINT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hermite_interpolation: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define HINT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hermite_interpolation: next-cycle check failed");

`else

`define HINT_ASSERT_SAME(label, clk, rst, ante, cons)
`define HINT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/hint_pkg.sv
// Shared constants and types of the hermite interpolation block.
package hint_pkg;

  // Configuration registers: 16-bit Q2.14 values.
  localparam int unsigned REG_W  = 16;
  // Tangent weights 1+b, 1-b, 1-t: up to 17 bits signed.
  localparam int unsigned COEF_W = 17;
  localparam logic signed [COEF_W-1:0] Q14_ONE = 17'sd16384;

  // APB port.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    REG_TENSION = 1'b0,
    REG_BIAS    = 1'b1
  } reg_idx_t;

  // Pipeline stages.
  localparam int unsigned STAGES  = 8;
  localparam int unsigned ST_DIFF = 0;
  localparam int unsigned ST_SUM  = 1;
  localparam int unsigned ST_TAN  = 2;
  localparam int unsigned ST_COEF = 3;
  localparam int unsigned ST_H1   = 4;
  localparam int unsigned ST_H2   = 5;
  localparam int unsigned ST_H3   = 6;
  localparam int unsigned ST_OUT  = 7;

  typedef struct packed {
    logic [STAGES-1:0] load;
    logic [STAGES-1:0] valid;
  } pipe_ctrl_t;

endpackage

// File: rtl/core/hint_ifs.sv
// Valid/ready channel interfaces for samples in and interpolated values out.
interface hint_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned FRAC_WIDTH   = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_before;
  logic signed [SAMPLE_WIDTH-1:0] sample_start;
  logic signed [SAMPLE_WIDTH-1:0] sample_end;
  logic signed [SAMPLE_WIDTH-1:0] sample_after;
  logic        [FRAC_WIDTH-1:0]   position;

  modport source (
    output valid, sample_before, sample_start, sample_end, sample_after, position,
    input  ready
  );
  modport sink (
    input  valid, sample_before, sample_start, sample_end, sample_after, position,
    output ready
  );
endinterface

interface hint_out_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] interpolated;
  logic                           saturated;

  modport source (
    output valid, interpolated, saturated,
    input  ready
  );
  modport sink (
    input  valid, interpolated, saturated,
    output ready
  );
endinterface

// File: rtl/core/hermite_interpolation.sv
// Top level of the tension/bias cubic Hermite interpolator.
//
//   channel   dir  kind        payload
//   samples   in   valid/ready sample_before, sample_start, sample_end,
//                              sample_after, position
//   result    out  valid/ready interpolated, saturated
//   apb       in   APB r/w     tension (0x0), bias (0x4)
//
// Eight register stages; one transaction enters per cycle unless a stall at the
// result port has backed the pipe up. The depth follows the multiplier chain: the tangent
// sums, the tension scale and three Horner multiply-rounds each take a stage.
// rst is synchronous and clears the stage valid bits and both registers.
// Each stage holds while the stage after it is full and not moving, so a
// stall at the result port fills the bubbles first and loses nothing.
module hermite_interpolation #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned FRAC_WIDTH   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hint_pkg::ADDR_W-1:0] paddr,
  input  logic [hint_pkg::DATA_W-1:0] pwdata,
  output logic [hint_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // data channels
  hint_in_if.sink                     samples,
  hint_out_if.source                  result
);

  localparam int unsigned DW = SAMPLE_WIDTH + 1;
  localparam int unsigned MW = SAMPLE_WIDTH + FRAC_WIDTH + 8;

  logic signed [hint_pkg::REG_W-1:0] tension;
  logic signed [hint_pkg::REG_W-1:0] bias;
  hint_pkg::pipe_ctrl_t              ctrl;

  // tangent -> horner stage boundary
  logic signed [MW-1:0]           m0, m1;
  logic signed [DW-1:0]           d21;
  logic signed [SAMPLE_WIDTH-1:0] y1;
  logic        [FRAC_WIDTH-1:0]   mu;

  // Tension and bias; the user must write them only while the pipe is empty; the block does not enforce this.
  hint_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tension (tension),
    .bias    (bias)
  );

  // Valid bits travel with the data; each stage advances on its own ready.
  hint_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_ready (result.ready),
    .ctrl      (ctrl)
  );

  // Stages 1-3: differences, weighted sums, rounded tangents m0 and m1.
  hint_tangent #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_WIDTH   (FRAC_WIDTH)
  ) u_tangent (
    .clk     (clk),
    .ctrl    (ctrl),
    .y0      (samples.sample_before),
    .y1      (samples.sample_start),
    .y2      (samples.sample_end),
    .y3      (samples.sample_after),
    .mu      (samples.position),
    .tension (tension),
    .bias    (bias),
    .m0      (m0),
    .m1      (m1),
    .d21_o   (d21),
    .y1_o    (y1),
    .mu_o    (mu)
  );

  // Stages 4-8: coefficients, Horner evaluation, round and clip.
  hint_horner #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_WIDTH   (FRAC_WIDTH)
  ) u_horner (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .m0           (m0),
    .m1           (m1),
    .d21          (d21),
    .y1           (y1),
    .mu           (mu),
    .interpolated (result.interpolated),
    .saturated    (result.saturated)
  );

  // The last stage is the output register.
  assign result.valid = ctrl.valid[hint_pkg::ST_OUT];

endmodule

// File: rtl/core/hint_cfg.sv
// APB register file holding tension and bias.
module hint_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hint_pkg::ADDR_W-1:0]         paddr,
  input  logic [hint_pkg::DATA_W-1:0]         pwdata,
  output logic [hint_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  output logic signed [hint_pkg::REG_W-1:0]   tension,
  output logic signed [hint_pkg::REG_W-1:0]   bias
);

  logic               wr_en;
  hint_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = hint_pkg::reg_idx_t'(paddr[hint_pkg::ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tension <= '0;
      bias    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        hint_pkg::REG_TENSION: tension <= pwdata[hint_pkg::REG_W-1:0];
        hint_pkg::REG_BIAS:    bias    <= pwdata[hint_pkg::REG_W-1:0];
        default:               ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hint_pkg::REG_TENSION:
        prdata = {{(hint_pkg::DATA_W-hint_pkg::REG_W){1'b0}}, tension};
      hint_pkg::REG_BIAS:
        prdata = {{(hint_pkg::DATA_W-hint_pkg::REG_W){1'b0}}, bias};
      default:
        prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/hint_pipe_ctrl.sv
// Valid bits and per-stage ready chain of the interpolation pipeline.
`include "hermite_interpolation_macros.svh"

module hint_pipe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  output hint_pkg::pipe_ctrl_t ctrl
);

  localparam int unsigned N = hint_pkg::STAGES;

  logic [N-1:0] valid;
  logic [N-1:0] valid_next;
  logic [N:0]   rdy;
  logic [N-1:0] vin;

  // A stage takes new data when it is empty or its content moves on.
  always_comb begin
    rdy[N] = out_ready;
    for (int i = N - 1; i >= 0; i--) begin
      rdy[i] = ~valid[i] | rdy[i+1];
    end
  end

  always_comb begin
    vin        = {valid[N-2:0], in_valid};
    ctrl.valid = valid;
    for (int i = 0; i < N; i++) begin
      valid_next[i] = rdy[i] ? vin[i] : valid[i];
      ctrl.load[i]  = rdy[i] & vin[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign in_ready = rdy[0];

  // Any bubble in the pipe lets a new transaction in.
  `HINT_ASSERT_SAME(a_bubble_ready, clk, rst, !(&valid), in_ready)
  // Items in flight change only by transactions at either end.
  `HINT_ASSERT_SAME(a_item_count, clk, rst, !$past(rst), $countones(valid) == $countones($past(valid)) + $past(in_valid && in_ready) - $past(valid[N-1] && out_ready))
  // An accepted transaction lands in the first stage.
  `HINT_ASSERT_NEXT(a_first_stage, clk, rst, in_valid && in_ready, valid[0])

endmodule

// File: rtl/core/hint_tangent.sv
// Stages 1-3: sample differences, tangent sums, rounded tangents.
module hint_tangent #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned FRAC_WIDTH   = 16,
  localparam int unsigned DW   = SAMPLE_WIDTH + 1,
  localparam int unsigned SUMW = DW + hint_pkg::COEF_W + 1,
  localparam int unsigned PW   = SUMW + hint_pkg::COEF_W,
  localparam int unsigned SH   = 29 - FRAC_WIDTH,
  localparam int unsigned MW   = PW + 1 - SH
) (
  input  logic                             clk,
  input  hint_pkg::pipe_ctrl_t             ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0]   y0,
  input  logic signed [SAMPLE_WIDTH-1:0]   y1,
  input  logic signed [SAMPLE_WIDTH-1:0]   y2,
  input  logic signed [SAMPLE_WIDTH-1:0]   y3,
  input  logic        [FRAC_WIDTH-1:0]     mu,
  input  logic signed [hint_pkg::REG_W-1:0] tension,
  input  logic signed [hint_pkg::REG_W-1:0] bias,
  output logic signed [MW-1:0]             m0,
  output logic signed [MW-1:0]             m1,
  output logic signed [DW-1:0]             d21_o,
  output logic signed [SAMPLE_WIDTH-1:0]   y1_o,
  output logic        [FRAC_WIDTH-1:0]     mu_o
);

  localparam logic signed [PW:0] HALF = signed'((PW+1)'(64'd1 << (SH - 1)));

  logic signed [hint_pkg::COEF_W-1:0] p, q, r;

  logic signed [DW-1:0]           d10_s1, d21_s1, d32_s1;
  logic signed [SAMPLE_WIDTH-1:0] y1_s1, y1_s2;
  logic        [FRAC_WIDTH-1:0]   mu_s1, mu_s2;

  logic signed [SUMW-1:0] sum0, sum1, sum0_next, sum1_next;
  logic signed [DW-1:0]   d21_s2;

  logic signed [PW:0]     prod0, prod1, rnd0, rnd1;

  assign p = hint_pkg::Q14_ONE + hint_pkg::COEF_W'(bias);
  assign q = hint_pkg::Q14_ONE - hint_pkg::COEF_W'(bias);
  assign r = hint_pkg::Q14_ONE - hint_pkg::COEF_W'(tension);

  // Stage 1: neighbor differences.
  always_ff @(posedge clk) begin
    if (ctrl.load[hint_pkg::ST_DIFF]) begin
      d10_s1 <= DW'(y1) - DW'(y0);
      d21_s1 <= DW'(y2) - DW'(y1);
      d32_s1 <= DW'(y3) - DW'(y2);
      y1_s1  <= y1;
      mu_s1  <= mu;
    end
  end

  // Stage 2: bias-weighted sums, exact in Q.14.
  always_comb begin
    sum0_next = d10_s1 * p + d21_s1 * q;
    sum1_next = d21_s1 * p + d32_s1 * q;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[hint_pkg::ST_SUM]) begin
      sum0   <= sum0_next;
      sum1   <= sum1_next;
      d21_s2 <= d21_s1;
      y1_s2  <= y1_s1;
      mu_s2  <= mu_s1;
    end
  end

  // Stage 3: scale by tension, round half away from zero.
  always_comb begin
    prod0 = sum0 * r;
    prod1 = sum1 * r;
    rnd0  = prod0 + HALF - signed'((PW+1)'(prod0[PW]));
    rnd1  = prod1 + HALF - signed'((PW+1)'(prod1[PW]));
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[hint_pkg::ST_TAN]) begin
      m0    <= MW'(rnd0 >>> SH);
      m1    <= MW'(rnd1 >>> SH);
      d21_o <= d21_s2;
      y1_o  <= y1_s2;
      mu_o  <= mu_s2;
    end
  end

endmodule

// File: rtl/core/hint_horner.sv
// Stages 4-8: cubic coefficients, three Horner steps, round and saturate.
`include "hermite_interpolation_macros.svh"

module hint_horner #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned FRAC_WIDTH   = 16,
  localparam int unsigned DW  = SAMPLE_WIDTH + 1,
  localparam int unsigned MW  = SAMPLE_WIDTH + FRAC_WIDTH + 8,
  localparam int unsigned HW  = SAMPLE_WIDTH + FRAC_WIDTH + 12,
  localparam int unsigned HMW = HW + FRAC_WIDTH + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  hint_pkg::pipe_ctrl_t           ctrl,
  input  logic signed [MW-1:0]           m0,
  input  logic signed [MW-1:0]           m1,
  input  logic signed [DW-1:0]           d21,
  input  logic signed [SAMPLE_WIDTH-1:0] y1,
  input  logic        [FRAC_WIDTH-1:0]   mu,
  output logic signed [SAMPLE_WIDTH-1:0] interpolated,
  output logic                           saturated
);

  localparam logic signed [HMW-1:0] MUL_HALF = signed'(HMW'(64'd1 << (FRAC_WIDTH - 1)));
  localparam logic signed [HW-1:0]  OUT_HALF = signed'(HW'(64'd1 << (FRAC_WIDTH - 1)));
  localparam logic signed [HW-1:0]  OUT_MAX  =
    signed'({{(HW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}});
  localparam logic signed [HW-1:0]  OUT_MIN  =
    signed'({{(HW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}});
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = OUT_MAX[SAMPLE_WIDTH-1:0];
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = OUT_MIN[SAMPLE_WIDTH-1:0];

  // One Horner step: round(h * mu / 2^FRAC_WIDTH) + c.
  function automatic logic signed [HW-1:0] mac_round(
    input logic signed [HW-1:0]         h,
    input logic        [FRAC_WIDTH-1:0] m,
    input logic signed [HW-1:0]         c
  );
    logic signed [HMW-1:0] prod;
    prod = h * $signed({1'b0, m});
    prod = prod + MUL_HALF - signed'(HMW'(prod[HMW-1]));
    return HW'(prod >>> FRAC_WIDTH) + c;
  endfunction

  logic signed [HW-1:0]           c3, c2, c3_next, c2_next;
  logic signed [HW-1:0]           m0_s4, m0_s5, h1, h2, h3;
  logic signed [SAMPLE_WIDTH-1:0] y1_s4, y1_s5, y1_s6;
  logic        [FRAC_WIDTH-1:0]   mu_s4, mu_s5, mu_s6;
  logic signed [HW-1:0]           d21_x, rnd, v_full;

  // Stage 4: c3 = m0 + m1 - 2*d21, c2 = 3*d21 - 2*m0 - m1 (scaled by 2^FRAC_WIDTH).
  always_comb begin
    d21_x   = HW'(d21);
    c3_next = HW'(m0) + HW'(m1) - (d21_x <<< (FRAC_WIDTH + 1));
    c2_next = (d21_x <<< (FRAC_WIDTH + 1)) + (d21_x <<< FRAC_WIDTH)
              - (HW'(m0) <<< 1) - HW'(m1);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[hint_pkg::ST_COEF]) begin
      c3    <= c3_next;
      c2    <= c2_next;
      m0_s4 <= HW'(m0);
      y1_s4 <= y1;
      mu_s4 <= mu;
    end
  end

  // Stages 5-7: Horner steps with c2, m0, then y1.
  always_ff @(posedge clk) begin
    if (ctrl.load[hint_pkg::ST_H1]) begin
      h1    <= mac_round(c3, mu_s4, c2);
      m0_s5 <= m0_s4;
      y1_s5 <= y1_s4;
      mu_s5 <= mu_s4;
    end
    if (ctrl.load[hint_pkg::ST_H2]) begin
      h2    <= mac_round(h1, mu_s5, m0_s5);
      y1_s6 <= y1_s5;
      mu_s6 <= mu_s5;
    end
    if (ctrl.load[hint_pkg::ST_H3]) begin
      h3 <= mac_round(h2, mu_s6, HW'(y1_s6) <<< FRAC_WIDTH);
    end
  end

  // Stage 8: drop the fraction with rounding, clip to the sample range.
  always_comb begin
    rnd    = h3 + OUT_HALF - signed'(HW'(h3[HW-1]));
    v_full = rnd >>> FRAC_WIDTH;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[hint_pkg::ST_OUT]) begin
      if (v_full > OUT_MAX) begin
        interpolated <= SMP_MAX;
        saturated    <= 1'b1;
      end else if (v_full < OUT_MIN) begin
        interpolated <= SMP_MIN;
        saturated    <= 1'b1;
      end else begin
        interpolated <= v_full[SAMPLE_WIDTH-1:0];
        saturated    <= 1'b0;
      end
    end
  end

  // A clipped result sits exactly on a range limit.
  `HINT_ASSERT_SAME(a_sat_limit, clk, rst, ctrl.valid[hint_pkg::ST_OUT] && saturated, interpolated == SMP_MAX || interpolated == SMP_MIN)

endmodule

// File: bench/hint_result_checker.sv
// Checker of the hermite interpolator: predicts each result and compares it with the block's output.
module hint_result_checker
  import hint_pkg::*;
#(
  parameter int unsigned SW = 16,
  parameter int unsigned FW = 16
) (
  input  logic                clk,
  input  logic                rst,
  hint_in_if                  samples,
  hint_out_if                 result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic [DATA_W-1:0]   prdata,
  input  logic                pready,
  output int unsigned         mismatches,
  output int unsigned         outstanding,
  output int unsigned         results_checked,
  output int unsigned         results_clipped
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [SW-1:0] y0;
    logic signed [SW-1:0] y1;
    logic signed [SW-1:0] y2;
    logic signed [SW-1:0] y3;
    logic        [FW-1:0] mu;
    logic signed [SW-1:0] interpolated;
    logic                 saturated;
  } interp_case_t;

  logic signed [REG_W-1:0] tension_q;
  logic signed [REG_W-1:0] bias_q;
  interp_case_t            pending_interp_q[$];

  // Round x / 2^sh to nearest, ties away from zero.
  function automatic wide_t round_shift(input wide_t x, input int unsigned sh);
    wide_t mag;
    mag = (x < 0) ? -x : x;
    mag = (mag + (128'sd1 <<< (sh - 1))) >>> sh;
    return (x < 0) ? -mag : mag;
  endfunction

  function automatic interp_case_t predict_interp(
    input logic signed [SW-1:0]    y0_in,
    input logic signed [SW-1:0]    y1_in,
    input logic signed [SW-1:0]    y2_in,
    input logic signed [SW-1:0]    y3_in,
    input logic        [FW-1:0]    mu_in,
    input logic signed [REG_W-1:0] tens,
    input logic signed [REG_W-1:0] bs
  );
    wide_t y0, y1, y2, y3, mu, one, p, q, r, s0, s1, m0, m1, c3, c2, h, v, hi, lo;
    interp_case_t e;
    y0  = y0_in;
    y1  = y1_in;
    y2  = y2_in;
    y3  = y3_in;
    mu  = $signed({{(128-FW){1'b0}}, mu_in});
    one = 128'sd1 <<< FW;
    p   = 128'sd16384 + bs;
    q   = 128'sd16384 - bs;
    r   = 128'sd16384 - tens;
    // Tangent sums are exact in Q.14; the tension scale lands them in Q.FW.
    s0  = (y1 - y0) * p + (y2 - y1) * q;
    s1  = (y2 - y1) * p + (y3 - y2) * q;
    m0  = round_shift(s0 * r, 29 - FW);
    m1  = round_shift(s1 * r, 29 - FW);
    c3  = 128'sd2 * (y1 - y2) * one + m0 + m1;
    c2  = 128'sd3 * (y2 - y1) * one - 128'sd2 * m0 - m1;
    h   = c3;
    h   = round_shift(h * mu, FW) + c2;
    h   = round_shift(h * mu, FW) + m0;
    h   = round_shift(h * mu, FW) + y1 * one;
    v   = round_shift(h, FW);
    hi  = (128'sd1 <<< (SW - 1)) - 1;
    lo  = -(128'sd1 <<< (SW - 1));
    e.saturated = 1'b0;
    if (v > hi) begin
      v = hi;
      e.saturated = 1'b1;
    end
    if (v < lo) begin
      v = lo;
      e.saturated = 1'b1;
    end
    e.y0 = y0_in;
    e.y1 = y1_in;
    e.y2 = y2_in;
    e.y3 = y3_in;
    e.mu = mu_in;
    e.interpolated = v[SW-1:0];
    return e;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    interp_case_t exp_item;
    interp_case_t new_item;
    if (rst) begin
      tension_q = '0;
      bias_q = '0;
      pending_interp_q.delete();
      mismatches = 0;
      outstanding = 0;
      results_checked = 0;
      results_clipped = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[2])
            REG_TENSION: tension_q = pwdata[REG_W-1:0];
            REG_BIAS:    bias_q = pwdata[REG_W-1:0];
            default: ;
          endcase
        end else begin
          case (paddr[2])
            REG_TENSION: if (prdata[REG_W-1:0] !== tension_q)
              report_mismatch($sformatf("tension read %0h, written %0h",
                                        prdata[REG_W-1:0], tension_q));
            REG_BIAS: if (prdata[REG_W-1:0] !== bias_q)
              report_mismatch($sformatf("bias read %0h, written %0h",
                                        prdata[REG_W-1:0], bias_q));
            default: ;
          endcase
        end
      end
      // Retire the oldest prediction before queuing the new one.
      if (result.valid && result.ready) begin
        if (pending_interp_q.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          exp_item = pending_interp_q.pop_front();
          results_checked++;
          if (exp_item.saturated) results_clipped++;
          if (result.interpolated !== exp_item.interpolated)
            report_mismatch($sformatf(
              "interpolated %0d, want %0d (y %0d %0d %0d %0d, mu %0d, t %0d, b %0d)",
              result.interpolated, exp_item.interpolated, exp_item.y0, exp_item.y1,
              exp_item.y2, exp_item.y3, exp_item.mu, tension_q, bias_q));
          if (result.saturated !== exp_item.saturated)
            report_mismatch($sformatf(
              "saturated %0b, want %0b (y %0d %0d %0d %0d, mu %0d)",
              result.saturated, exp_item.saturated, exp_item.y0, exp_item.y1,
              exp_item.y2, exp_item.y3, exp_item.mu));
        end
      end
      if (samples.valid && samples.ready) begin
        new_item = predict_interp(samples.sample_before, samples.sample_start,
                                  samples.sample_end, samples.sample_after,
                                  samples.position, tension_q, bias_q);
        pending_interp_q = {pending_interp_q, new_item};
      end
      outstanding = pending_interp_q.size();
    end
  end

endmodule

// File: bench/tb_hermite_interpolation.sv
// Top of the hermite interpolator testbench: clock, reset, stimulus, back-pressure and verdict.
module tb_hermite_interpolation;
  timeunit 1ns;
  timeprecision 1ps;

  import hint_pkg::*;

  localparam int unsigned SW            = 16;
  localparam int unsigned FW            = 16;
  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned RESET_CYCLES  = 5;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 88;
  localparam int unsigned LONG_HOLD     = 150;

  localparam logic [ADDR_W-1:0]    TENSION_ADDR = ADDR_W'(4 * REG_TENSION);
  localparam logic [ADDR_W-1:0]    BIAS_ADDR    = ADDR_W'(4 * REG_BIAS);
  localparam logic [REG_W-1:0]     ONE_Q14      = REG_W'(Q14_ONE);
  localparam logic signed [SW-1:0] S_MAX        = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN        = {1'b1, {(SW-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  hint_in_if  #(.SAMPLE_WIDTH(SW), .FRAC_WIDTH(FW)) samples_if ();
  hint_out_if #(.SAMPLE_WIDTH(SW))                  result_if ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned results_clipped;

  // Knobs of the sender and the receiver, and run counters.
  bit          tx_steady    = 1'b0;
  bit          rx_steady    = 1'b0;
  int unsigned rx_hold_req  = 0;
  int unsigned shapes_used  = 0;
  int unsigned cycle_count  = 0;
  int unsigned input_stalls = 0;

  hermite_interpolation #(
    .SAMPLE_WIDTH(SW),
    .FRAC_WIDTH  (FW)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .samples(samples_if),
    .result (result_if)
  );

  hint_result_checker #(
    .SW(SW),
    .FW(FW)
  ) i_check (
    .clk            (clk),
    .rst            (rst),
    .samples        (samples_if),
    .result         (result_if),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .results_clipped(results_clipped)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Watchdog: count cycles, note input back-pressure, and bail out on a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (samples_if.valid && !samples_if.ready) input_stalls++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** hermite_interpolation: FAILED **");
      $finish;
    end
  end

  // Pick a sample from the corners of the signed range.
  function automatic logic signed [SW-1:0] corner_sample();
    case ($urandom_range(4))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return '1;
      default: return {{(SW-1){1'b0}}, 1'b1};
    endcase
  endfunction

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic [ADDR_W-1:0] addr, input logic wr,
                            input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Change tension and bias only with the pipeline drained, then read both back.
  task automatic set_shape(input logic [REG_W-1:0] tens, input logic [REG_W-1:0] bs);
    wait (outstanding == 0);
    repeat (STAGES) @(posedge clk);
    // Upper data bits carry junk: only the low half of the word is a register.
    apb_access(TENSION_ADDR, 1'b1, {16'($urandom()), tens});
    apb_access(BIAS_ADDR, 1'b1, {16'($urandom()), bs});
    apb_access(TENSION_ADDR, 1'b0, '0);
    apb_access(BIAS_ADDR, 1'b0, '0);
    shapes_used++;
  endtask

  // Offer one transaction after a random gap and hold it until accepted.
  // Called and returning at a falling edge; valid drops only when a gap is due.
  task automatic send_sample(input logic signed [SW-1:0] y0, input logic signed [SW-1:0] y1,
                             input logic signed [SW-1:0] y2, input logic signed [SW-1:0] y3,
                             input logic [FW-1:0] mu);
    int unsigned gap;
    int unsigned roll;
    roll = $urandom_range(99);
    if (tx_steady || roll < 55) gap = 0;
    else if (roll < 95) gap = $urandom_range(3, 1);
    else gap = $urandom_range(40, 15);
    if (gap != 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_if.valid         <= 1'b1;
    samples_if.sample_before <= y0;
    samples_if.sample_start  <= y1;
    samples_if.sample_end    <= y2;
    samples_if.sample_after  <= y3;
    samples_if.position      <= mu;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random ready with short and occasional long stalls, a steady mode,
  // and a long hold-off on request so the pipeline backs up into the input.
  initial begin : rx_side
    int unsigned stall_left;
    int unsigned roll;
    stall_left = 0;
    result_if.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall_left != 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else if (rx_steady) begin
        result_if.ready <= 1'b1;
      end else begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          result_if.ready <= 1'b1;
        end else begin
          result_if.ready <= 1'b0;
          stall_left = (roll < 97) ? $urandom_range(2, 0) : $urandom_range(40, 12);
        end
      end
    end
  end

  initial begin : tx_side
    logic signed [SW-1:0] wave[4];
    logic signed [SW-1:0] a, b, c, d;
    logic [FW-1:0]        mu;
    int                   tv, bv;
    int unsigned          roll;
    samples_if.valid         = 1'b0;
    samples_if.sample_before = '0;
    samples_if.sample_start  = '0;
    samples_if.sample_end    = '0;
    samples_if.sample_after  = '0;
    samples_if.position      = '0;

    // Hold reset, then release it away from the sampling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Registers must read back as zero straight out of reset.
    apb_access(TENSION_ADDR, 1'b0, '0);
    apb_access(BIAS_ADDR, 1'b0, '0);
    shapes_used++;

    // Directed part with the reset tangents (Catmull-Rom like).
    send_sample('0, '0, '0, '0, '0);
    send_sample(16'sd100, 16'sd200, 16'sd300, 16'sd400, '0);          // start point exactly
    send_sample(16'sd100, 16'sd200, 16'sd300, 16'sd400, 16'hFFFF);    // just short of end
    send_sample(-16'sd1000, 16'sd5000, -16'sd7000, 16'sd3000, 16'h8000);
    send_sample(S_MAX, S_MAX, S_MAX, S_MAX, 16'h4000);
    send_sample(S_MIN, S_MIN, S_MIN, S_MIN, 16'hC000);
    send_sample(S_MIN, S_MAX, S_MAX, S_MIN, 16'h8000);                // overshoot above
    send_sample(S_MAX, S_MIN, S_MIN, S_MAX, 16'h8000);                // overshoot below
    send_sample(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'hAAAA);
    send_sample(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'h5555);
    send_sample(-16'sd1, 16'sd0, 16'sd1, 16'sd2, 16'h0001);

    // Full tension flattens both tangents: no overshoot even across full swings.
    samples_if.valid <= 1'b0;
    set_shape(ONE_Q14, '0);
    send_sample(S_MIN, S_MAX, S_MAX, S_MIN, 16'h8000);
    send_sample(-16'sd300, 16'sd1200, -16'sd800, 16'sd50, 16'h2345);

    // Registers beyond +-1.0 are used as raw two's complement.
    samples_if.valid <= 1'b0;
    set_shape(16'h8000, 16'h7FFF);
    send_sample(S_MIN, S_MAX, S_MAX, S_MIN, 16'h8000);
    send_sample(S_MAX, S_MIN, S_MIN, S_MAX, 16'h8000);
    send_sample(S_MAX, S_MIN, S_MAX, S_MIN, '0);
    send_sample(S_MIN, S_MAX, S_MIN, S_MAX, 16'hFFFF);

    samples_if.valid <= 1'b0;
    set_shape(16'h7FFF, 16'h8000);
    send_sample(S_MIN, S_MAX, S_MIN, S_MAX, 16'h6000);
    send_sample(16'sd12000, -16'sd4000, 16'sd9000, -16'sd15000, 16'h1000);

    samples_if.valid <= 1'b0;
    set_shape(16'(-16384), 16'(16384));
    send_sample(S_MIN, S_MAX, S_MAX, S_MIN, 16'h3000);
    send_sample(16'sd0, -16'sd20000, 16'sd20000, 16'sd0, 16'hD000);

    // Random phases, each with its own tension and bias.
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      samples_if.valid <= 1'b0;
      roll = $urandom_range(99);
      tv = (roll < 70) ? int'($urandom_range(32768)) - 16384 : int'($urandom_range(65535)) - 32768;
      roll = $urandom_range(99);
      bv = (roll < 70) ? int'($urandom_range(32768)) - 16384 : int'($urandom_range(65535)) - 32768;
      set_shape(16'(tv), 16'(bv));

      // Phase 1 holds off the receiver for a long stretch while input keeps coming;
      // phase 4 runs both sides flat out.
      if (ph == 1) rx_hold_req = LONG_HOLD;
      rx_steady = (ph == 4);
      for (int i = 0; i < 4; i++) wave[i] = SW'($urandom());

      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        tx_steady = (ph == 4) || (ph == 1 && n < 60);
        roll = $urandom_range(99);
        if (roll < 35) begin
          // Slide a window along a wandering waveform, as a resampler would.
          wave[0] = wave[1];
          wave[1] = wave[2];
          wave[2] = wave[3];
          wave[3] = wave[2] + SW'(int'($urandom_range(4000)) - 2000);
          a = wave[0];
          b = wave[1];
          c = wave[2];
          d = wave[3];
        end else if (roll < 65) begin
          a = SW'($urandom());
          b = SW'($urandom());
          c = SW'($urandom());
          d = SW'($urandom());
        end else if (roll < 85) begin
          a = corner_sample();
          b = corner_sample();
          c = corner_sample();
          d = corner_sample();
        end else begin
          a = SW'(int'($urandom_range(16)) - 8);
          b = SW'(int'($urandom_range(16)) - 8);
          c = SW'(int'($urandom_range(16)) - 8);
          d = SW'(int'($urandom_range(16)) - 8);
        end
        roll = $urandom_range(99);
        if (roll < 8) mu = '0;
        else if (roll < 12) mu = '1;
        else if (roll < 16) mu = FW'(1);
        else mu = FW'($urandom());
        send_sample(a, b, c, d, mu);
      end
    end
    samples_if.valid <= 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    // Drain: every prediction must be matched, then let the pipe settle.
    wait (outstanding == 0);
    repeat (2 * STAGES) @(posedge clk);

    $display("Checked %0d interpolations under %0d tension/bias settings, %0d clipped.",
             results_checked, shapes_used, results_clipped);
    $display("Input was held off for %0d cycles by output back-pressure.", input_stalls);
    if (mismatches == 0) begin
      $display("** hermite_interpolation: PASSED **");
    end else begin
      $display("** hermite_interpolation: FAILED **");
    end
    $finish;
  end

endmodule

// File: hermite_interpolation.f
+incdir+rtl/core
rtl/core/hint_pkg.sv
rtl/core/hint_ifs.sv
rtl/core/hint_cfg.sv
rtl/core/hint_pipe_ctrl.sv
rtl/core/hint_tangent.sv
rtl/core/hint_horner.sv
rtl/core/hermite_interpolation.sv
bench/hint_result_checker.sv
bench/tb_hermite_interpolation.sv
